>>> design/hvgs_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the saturating adder of the HMM Viterbi Gaussian scorer.
// No dependencies; every module of the scorer imports it.
package hvgs_pkg;

  // Field widths of the cell bus; wide enough for every supported model size.
  localparam int unsigned IDX_W = 7;
  localparam int unsigned DIM_FW = 6;

  localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] SCORE_MAX = 32'sh7FFF_FFFF;

  typedef enum logic [2:0] {
    OP_MEAN   = 3'd0,
    OP_HPREC  = 3'd1,
    OP_CONST  = 3'd2,
    OP_TRANS  = 3'd3,
    OP_START  = 3'd4,
    OP_FEAT   = 3'd5,
    OP_FINISH = 3'd6
  } op_t;

  typedef enum logic [0:0] {
    CFG_STATES = 1'b0,
    CFG_DIMS   = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FEAT,
    ST_EMIT,
    ST_PASS,
    ST_COMMIT,
    ST_FIN
  } ctl_state_t;

  // Word travelling down the cell chain: a feature element or a source token.
  typedef struct packed {
    logic                valid;
    logic                feat;
    logic [IDX_W-1:0]    idx;
    logic [DIM_FW-1:0]   dim;
    logic signed [15:0]  x;
    logic                tok_ok;
    logic signed [31:0]  tok;
  } stream_t;

  typedef struct packed {
    logic start;
    logic emit;
    logic commit;
    logic clr_best;
    logic fin_mode;
  } cell_cmd_t;

  typedef struct packed {
    logic              mean_we;
    logic              hp_we;
    logic              const_we;
    logic              lt_we;
    logic              lt_all;
    logic [IDX_W-1:0]  slot;
    logic [IDX_W-1:0]  row;
    logic [DIM_FW-1:0] dim;
    logic [31:0]       data;
    logic              present;
  } load_t;

  typedef struct packed {
    logic signed [31:0] tok;
    logic               tok_ok;
    logic signed [31:0] best;
    logic               best_ok;
    logic               clip;
  } cell_stat_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               clip;
  } sat_t;

  function automatic sat_t sat_add(input logic signed [31:0] a, input logic signed [31:0] b);
    logic signed [32:0] s;
    sat_t r;
    s = {a[31], a} + {b[31], b};
    r.clip = (s[32] != s[31]);
    if (r.clip) begin
      r.val = s[32] ? SCORE_MIN : SCORE_MAX;
    end else begin
      r.val = s[31:0];
    end
    return r;
  endfunction

endpackage

>>> design/hvgs_cell.sv
`timescale 1ns / 1ps
// One emitting-state cell: Gaussian tables, one transition column, accumulator and token.
// Depends on hvgs_pkg.
module hvgs_cell #(
  parameter int unsigned K        = 0,
  parameter int unsigned MAX_DIMS = 32,
  parameter int unsigned ROWS     = 18
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hvgs_pkg::cell_cmd_t    cmd,
  input  hvgs_pkg::load_t        load,
  input  logic                   active,
  input  hvgs_pkg::stream_t      s_in,
  output hvgs_pkg::stream_t      s_out,
  output hvgs_pkg::cell_stat_t   stat
);
  import hvgs_pkg::*;

  localparam int unsigned DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned ROW_W = $clog2(ROWS);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(K);

  logic signed [15:0] mean_mem [MAX_DIMS];
  logic [15:0]        hp_mem   [MAX_DIMS];
  logic [32:0]        lt_mem   [ROWS];

  logic signed [15:0] mean_rd_r;
  logic [15:0]        hp_rd_r;
  logic [32:0]        lt_rd_r;
  logic signed [31:0] const_r;

  stream_t            a_r, b_r;
  logic signed [31:0] inner_r;
  logic               pres_b_r;
  logic [32:0]        sq_r;
  logic [15:0]        hp_b_r;
  logic [40:0]        term_r;
  logic               c_vld_r;
  logic signed [31:0] acc_r;
  logic signed [31:0] emit_r;
  logic signed [31:0] best_r;
  logic               best_ok_r;
  logic signed [31:0] tok_r;
  logic               tok_ok_r;

  logic signed [16:0] diff;
  logic signed [33:0] sq_full;
  logic signed [31:0] emit_op;
  sat_t               ia, ib, ie;
  logic               use_a, use_b, use_c, take_b;
  logic [48:0]        prod;
  logic signed [42:0] acc_diff;
  logic               acc_lo;
  logic signed [31:0] acc_new;

  // table writes and registered reads
  always_ff @(posedge clk) begin
    if (load.mean_we && load.slot == MY_IDX) begin
      mean_mem[load.dim[DIM_W-1:0]] <= load.data[15:0];
    end
    if (load.hp_we && load.slot == MY_IDX) begin
      hp_mem[load.dim[DIM_W-1:0]] <= load.data[15:0];
    end
    if (load.lt_we && (load.lt_all || load.slot == MY_IDX)) begin
      lt_mem[load.row[ROW_W-1:0]] <= {load.present, load.data};
    end
    if (load.const_we && load.slot == MY_IDX) begin
      const_r <= load.data;
    end
    mean_rd_r <= mean_mem[s_in.dim[DIM_W-1:0]];
    hp_rd_r   <= hp_mem[s_in.dim[DIM_W-1:0]];
    lt_rd_r   <= lt_mem[s_in.idx[ROW_W-1:0]];
  end

  always_comb begin
    diff     = {a_r.x[15], a_r.x} - {mean_rd_r[15], mean_rd_r};
    sq_full  = diff * diff;
    emit_op  = cmd.fin_mode ? '0 : emit_r;
    ia       = sat_add(emit_op, lt_rd_r[31:0]);
    use_a    = a_r.valid & ~a_r.feat & a_r.tok_ok & lt_rd_r[32] & active;
    ib       = sat_add(b_r.tok, inner_r);
    use_b    = b_r.valid & ~b_r.feat & b_r.tok_ok & pres_b_r & active;
    take_b   = use_b & (~best_ok_r | (ib.val > best_r));
    prod     = sq_r * hp_b_r;
    acc_diff = {{11{acc_r[31]}}, acc_r} - $signed({2'b00, term_r});
    acc_lo   = acc_diff < -43'sd2147483648;
    acc_new  = acc_lo ? SCORE_MIN : acc_diff[31:0];
    use_c    = c_vld_r & active;
    ie       = sat_add(acc_r, const_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r       <= '0;
      b_r       <= '0;
      c_vld_r   <= 1'b0;
      acc_r     <= '0;
      tok_ok_r  <= 1'b0;
      best_ok_r <= 1'b0;
    end else begin
      a_r     <= s_in;
      b_r     <= a_r;
      c_vld_r <= b_r.valid & b_r.feat;
      if (cmd.start || cmd.emit) begin
        acc_r <= '0;
      end else if (use_c) begin
        acc_r <= acc_new;
      end
      if (cmd.start) begin
        tok_ok_r <= 1'b0;
      end else if (cmd.commit) begin
        tok_ok_r <= best_ok_r;
      end
      if (cmd.emit || cmd.clr_best) begin
        best_ok_r <= 1'b0;
      end else if (take_b) begin
        best_ok_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    inner_r  <= ia.val;
    pres_b_r <= lt_rd_r[32];
    sq_r     <= sq_full[32:0];
    hp_b_r   <= hp_rd_r;
    term_r   <= prod[48:8];
    if (cmd.emit) begin
      emit_r <= ie.val;
    end
    if (take_b) begin
      best_r <= ib.val;
    end
    if (cmd.commit) begin
      tok_r <= best_r;
    end
  end

  assign s_out        = b_r;
  assign stat.tok     = tok_r;
  assign stat.tok_ok  = tok_ok_r;
  assign stat.best    = best_r;
  assign stat.best_ok = best_ok_r;
  assign stat.clip    = (use_a & ia.clip) | (use_b & ib.clip) | (use_c & acc_lo)
                      | (cmd.emit & active & ie.clip);

endmodule

>>> design/hmm_viterbi_gaussian_scorer_top.sv
`timescale 1ns / 1ps
// Top level of the HMM Viterbi scorer: control sequencer and the chain of state cells.
// Depends on hvgs_pkg and hvgs_cell.
//
//  port group   dir  handshake          carries
//  in_*         in   in_valid/in_stall  op, state/dim/target index, value, present, frame end
//  out_*        out  out_valid/out_stall score, no_path, saturated (one word per finish)
//  cfg_*        in   cfg_we             states_in_use (index 0), dims_in_use (index 1)
//
// A feature element walks the chain of cells; when it ends a frame, the emission, a token
// pass through the chain and a commit follow; a finish passes the tokens through the chain
// once more. After reset the transition columns are swept to "no transition", with
// in_stall high. A finish is held off while the previous result word is still stalled;
// every other op is taken regardless of out_stall.
module hmm_viterbi_gaussian_scorer_top #(
  parameter int unsigned MAX_STATES = 16,
  parameter int unsigned MAX_DIMS   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_op,
  input  logic [4:0]         in_state_index,
  input  logic [4:0]         in_dim_index,
  input  logic [4:0]         in_target_index,
  input  logic signed [31:0] in_value,
  input  logic               in_transition_present,
  input  logic               in_frame_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_score,
  output logic               out_no_path,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [5:0]         cfg_data
);
  import hvgs_pkg::*;

  localparam int unsigned NC     = MAX_STATES + 1;
  localparam int unsigned ROWS   = MAX_STATES + 2;
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned CELL_W = $clog2(NC);
  localparam int unsigned CNT_W  = $clog2(3 * MAX_STATES + 3) + 1;
  localparam logic [7:0]  MAX_S8 = 8'(MAX_STATES);
  localparam logic [7:0]  MAX_D8 = 8'(MAX_DIMS);
  localparam logic [7:0]  ROWS8  = 8'(ROWS);

  ctl_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [4:0]         cfg_states_r;
  logic [5:0]         cfg_dims_r;
  logic               fend_r;
  logic               entry_ok_r;
  logic               sat_seen_r;
  logic               fin_sat_r;
  logic               out_valid_r;
  logic signed [31:0] out_score_r;
  logic               out_no_path_r;
  logic               out_sat_r;

  cell_cmd_t          cmd;
  load_t              ld;
  stream_t            inj;
  stream_t            sout [NC];
  cell_stat_t         stat [NC];
  logic [NC-1:0]      act;
  logic [NC-1:0]      clip_vec;
  logic               any_clip;
  logic               accept;
  logic               out_load;

  logic [7:0]         s8, d8, st8, dim8, tg8;
  logic [CNT_W-1:0]   s_c, s2, s3;
  logic               st_ok, dim_ok;
  logic [ROW_W-1:0]   src, src_m1;
  logic [CELL_W-1:0]  exit_cell;

  // effective sizes, clamped to the supported range
  always_comb begin
    if (cfg_states_r == '0) begin
      s8 = 8'd1;
    end else if ({3'b000, cfg_states_r} > MAX_S8) begin
      s8 = MAX_S8;
    end else begin
      s8 = {3'b000, cfg_states_r};
    end
    if (cfg_dims_r == '0) begin
      d8 = 8'd1;
    end else if ({2'b00, cfg_dims_r} > MAX_D8) begin
      d8 = MAX_D8;
    end else begin
      d8 = {2'b00, cfg_dims_r};
    end
    st8    = {3'b000, in_state_index};
    dim8   = {3'b000, in_dim_index};
    tg8    = {3'b000, in_target_index};
    s_c    = CNT_W'(s8);
    s2     = s_c << 1;
    s3     = s2 + s_c;
    st_ok  = (st8 != 8'd0) && (st8 <= s8);
    dim_ok = dim8 < d8;
  end

  // sequencer: next state, cell commands, table loads and chain injection
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    ld        = '0;
    inj       = '0;
    in_stall  = 1'b1;
    accept    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ld.lt_we  = 1'b1;
        ld.lt_all = 1'b1;
        ld.row    = IDX_W'(cnt_r);
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROWS - 1)) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      ST_IDLE: begin
        in_stall = (in_op == OP_FINISH) && out_valid_r;
        accept   = in_valid && !in_stall;
        ld.data  = in_value;
        ld.dim   = DIM_FW'(in_dim_index);
        if (accept) begin
          case (in_op)
            OP_MEAN: begin
              ld.mean_we = st_ok && dim_ok;
              ld.slot    = IDX_W'(st8 - 8'd1);
            end
            OP_HPREC: begin
              ld.hp_we = st_ok && dim_ok;
              ld.slot  = IDX_W'(st8 - 8'd1);
            end
            OP_CONST: begin
              ld.const_we = st_ok;
              ld.slot     = IDX_W'(st8 - 8'd1);
            end
            OP_TRANS: begin
              // the entry column is never read: drop those loads
              ld.lt_we   = (st8 < ROWS8) && (tg8 < ROWS8) && (tg8 != 8'd0);
              ld.slot    = IDX_W'(tg8 - 8'd1);
              ld.row     = IDX_W'(st8);
              ld.present = in_transition_present;
            end
            OP_START: begin
              cmd.start = 1'b1;
            end
            OP_FEAT: begin
              inj.valid = dim_ok;
              inj.feat  = 1'b1;
              inj.dim   = DIM_FW'(in_dim_index);
              inj.x     = in_value[15:0];
              state_nxt = ST_FEAT;
              cnt_nxt   = '0;
            end
            OP_FINISH: begin
              cmd.clr_best = 1'b1;
              state_nxt    = ST_FIN;
              cnt_nxt      = '0;
            end
            default: ;
          endcase
        end
      end
      ST_FEAT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == s2) begin
          state_nxt = fend_r ? ST_EMIT : ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_PASS;
        cnt_nxt   = '0;
      end
      ST_PASS: begin
        // feed sources 0..S into the chain, then let the last one drain
        inj.valid = cnt_r <= s_c;
        inj.idx   = IDX_W'(cnt_r);
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == s3) begin
          state_nxt = ST_COMMIT;
          cnt_nxt   = '0;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_FIN: begin
        // sources 1..S only; the cell holding the exit column keeps the best
        cmd.fin_mode = 1'b1;
        inj.valid    = cnt_r < s_c;
        inj.idx      = IDX_W'(cnt_r + 1'b1);
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == s3 + CNT_W'(2)) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // source token: row 0 is the entry state, row i lives in cell i-1
    src    = inj.idx[ROW_W-1:0];
    src_m1 = src - 1'b1;
    if (inj.feat) begin
      inj.tok_ok = 1'b0;
      inj.tok    = '0;
    end else if (src == '0) begin
      inj.tok_ok = entry_ok_r;
      inj.tok    = '0;
    end else begin
      inj.tok_ok = stat[src_m1[CELL_W-1:0]].tok_ok;
      inj.tok    = stat[src_m1[CELL_W-1:0]].tok;
    end
  end

  // frames use cells below S; a finish uses only the cell holding column S+1
  always_comb begin
    for (int k = 0; k < NC; k++) begin
      act[k]      = cmd.fin_mode ? (8'(k) == s8) : (8'(k) < s8);
      clip_vec[k] = stat[k].clip;
    end
    any_clip  = |clip_vec;
    exit_cell = s8[CELL_W-1:0];
  end

  for (genvar k = 0; k < NC; k++) begin : g_cell
    hvgs_cell #(
      .K        (k),
      .MAX_DIMS (MAX_DIMS),
      .ROWS     (ROWS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .load   (ld),
      .active (act[k]),
      .s_in   ((k == 0) ? inj : sout[(k == 0) ? 0 : k - 1]),
      .s_out  (sout[k]),
      .stat   (stat[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cnt_r        <= '0;
      cfg_states_r <= 5'd16;
      cfg_dims_r   <= 6'd32;
      fend_r       <= 1'b0;
      entry_ok_r   <= 1'b1;
      sat_seen_r   <= 1'b0;
      fin_sat_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_STATES: cfg_states_r <= cfg_data[4:0];
          CFG_DIMS:   cfg_dims_r   <= cfg_data;
          default: ;
        endcase
      end
      if (accept && in_op == OP_FEAT) begin
        fend_r <= in_frame_end;
      end
      if (cmd.start) begin
        entry_ok_r <= 1'b1;
      end else if (cmd.commit) begin
        entry_ok_r <= 1'b0;
      end
      // finish clips go only into the result word, never into the running flag
      if (cmd.start) begin
        sat_seen_r <= 1'b0;
      end else if (any_clip && !cmd.fin_mode) begin
        sat_seen_r <= 1'b1;
      end
      if (cmd.clr_best) begin
        fin_sat_r <= sat_seen_r;
      end else if (any_clip && cmd.fin_mode) begin
        fin_sat_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_score_r   <= stat[exit_cell].best_ok ? stat[exit_cell].best : SCORE_MIN;
      out_no_path_r <= !stat[exit_cell].best_ok;
      out_sat_r     <= fin_sat_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_score     = out_score_r;
  assign out_no_path   = out_no_path_r;
  assign out_saturated = out_sat_r;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the HMM Viterbi Gaussian scorer: loads models, streams frames,
// and checks every finish word against a Q16.16 max-plus predictor. Depends on hvgs_pkg.
module testbench;
  import hvgs_pkg::*;

  localparam int NST  = 16;
  localparam int NDIM = 32;
  localparam int NROW = NST + 2;

  // Scoreboard: mirrors the scorer's tables, tokens and accumulators and holds the exit
  // scores still owed by the block.
  class viterbi_board;
    int          mean_tab [NST*NDIM];
    int unsigned hprec_tab [NST*NDIM];
    int          const_tab [NST];
    bit          mean_set [NST*NDIM];
    bit          hprec_set [NST*NDIM];
    bit          const_set [NST];
    int          trans_val [NROW*NROW];
    bit          trans_ok [NROW*NROW];
    int          tok_val [NROW];
    bit          tok_ok [NROW];
    int          acc [NST];
    bit          clipped;
    int unsigned states_reg, dims_reg;
    int          score_q [$];
    bit          nopath_q [$];
    bit          sat_q [$];
    int          errors;

    function new();
      states_reg = 16;
      dims_reg = 32;
      foreach (trans_ok[k]) trans_ok[k] = 0;
      foreach (mean_set[k]) begin
        mean_set[k] = 0;
        hprec_set[k] = 0;
      end
      foreach (const_set[k]) const_set[k] = 0;
      reset_tokens();
      errors = 0;
    endfunction

    function int n_states();
      if (states_reg < 1) return 1;
      return (states_reg > NST) ? NST : states_reg;
    endfunction

    function int n_dims();
      if (dims_reg < 1) return 1;
      return (dims_reg > NDIM) ? NDIM : dims_reg;
    endfunction

    function void reset_tokens();
      foreach (tok_ok[k]) begin
        tok_ok[k] = 0;
        tok_val[k] = 0;
      end
      tok_ok[0] = 1;
      foreach (acc[k]) acc[k] = 0;
      clipped = 0;
    endfunction

    // Saturate to 32 bits and latch the clip flag.
    function int clip32(longint s);
      if (s > 64'sd2147483647) begin
        clipped = 1;
        return 32'h7FFF_FFFF;
      end
      if (s < -64'sd2147483648) begin
        clipped = 1;
        return 32'h8000_0000;
      end
      return int'(s);
    endfunction

    function void write_cfg(cfg_reg_t idx, int unsigned data);
      if (idx == CFG_STATES) states_reg = data & 5'h1F;
      else dims_reg = data & 6'h3F;
    endfunction

    // A dim is safe to stream when it is out of range or fully loaded for every state.
    function bit dim_ready(int dim);
      if (dim >= n_dims()) return 1;
      for (int j = 0; j < n_states(); j++)
        if (!mean_set[j*NDIM+dim] || !hprec_set[j*NDIM+dim]) return 0;
      return 1;
    endfunction

    function bit consts_ready();
      for (int j = 0; j < n_states(); j++)
        if (!const_set[j]) return 0;
      return 1;
    endfunction

    function void close_frame();
      int emit [NST+1];
      int nv [NROW];
      bit nok [NROW];
      int s, inner, cand;
      s = n_states();
      for (int j = 1; j <= s; j++)
        emit[j] = clip32(longint'(acc[j-1]) + const_tab[j-1]);
      foreach (nok[j]) begin
        nok[j] = 0;
        nv[j] = 0;
      end
      for (int i = 0; i <= s; i++) begin
        if (!tok_ok[i]) continue;
        for (int j = 1; j <= s; j++) begin
          if (!trans_ok[i*NROW+j]) continue;
          inner = clip32(longint'(emit[j]) + trans_val[i*NROW+j]);
          cand = clip32(longint'(tok_val[i]) + inner);
          if (!nok[j] || cand > nv[j]) begin
            nok[j] = 1;
            nv[j] = cand;
          end
        end
      end
      tok_ok = nok;
      tok_val = nv;
      foreach (acc[k]) acc[k] = 0;
    endfunction

    // Note one accepted input word and queue the exit score it owes, if any.
    function void note_word(logic [2:0] op, int st, int dim, int tg, logic [31:0] val,
                            bit pres, bit fend);
      int s, d, best, c;
      bit found, keep;
      longint x, diff, term;
      s = n_states();
      d = n_dims();
      case (op)
        OP_MEAN, OP_HPREC, OP_CONST: begin
          if (st < 1 || st > s) return;
          if (op == OP_CONST) begin
            const_tab[st-1] = val;
            const_set[st-1] = 1;
          end else if (dim < d) begin
            if (op == OP_MEAN) begin
              mean_tab[(st-1)*NDIM+dim] = 32'($signed(val[15:0]));
              mean_set[(st-1)*NDIM+dim] = 1;
            end else begin
              hprec_tab[(st-1)*NDIM+dim] = 32'(val[15:0]);
              hprec_set[(st-1)*NDIM+dim] = 1;
            end
          end
        end
        OP_TRANS: begin
          if (st < NROW && tg < NROW) begin
            trans_val[st*NROW+tg] = val;
            trans_ok[st*NROW+tg] = pres;
          end
        end
        OP_START: reset_tokens();
        OP_FEAT: begin
          if (dim < d) begin
            x = 64'($signed(val[15:0]));
            for (int j = 0; j < s; j++) begin
              diff = x - mean_tab[j*NDIM+dim];
              term = (diff * diff * longint'(hprec_tab[j*NDIM+dim])) >>> 8;
              acc[j] = clip32(longint'(acc[j]) - term);
            end
          end
          if (fend) close_frame();
        end
        OP_FINISH: begin
          keep = clipped;
          found = 0;
          best = 0;
          for (int i = 1; i <= s; i++) begin
            if (!tok_ok[i] || !trans_ok[i*NROW+s+1]) continue;
            c = clip32(longint'(tok_val[i]) + trans_val[i*NROW+s+1]);
            if (!found || c > best) begin
              found = 1;
              best = c;
            end
          end
          score_q.push_back(found ? best : 32'h8000_0000);
          nopath_q.push_back(!found);
          sat_q.push_back(clipped);
          clipped = keep;
        end
        default: ;
      endcase
    endfunction

    function void check_word(logic [31:0] score, logic np, logic sat);
      int es;
      bit en, esat;
      if (score_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: score %h", score);
        return;
      end
      es = score_q.pop_front();
      en = nopath_q.pop_front();
      esat = sat_q.pop_front();
      if (score !== es || np !== en || sat !== esat) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected score %h no_path %0b sat %0b, got %h %0b %0b",
                   es, en, esat, score, np, sat);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_op;
  logic [4:0]         in_state_index;
  logic [4:0]         in_dim_index;
  logic [4:0]         in_target_index;
  logic signed [31:0] in_value;
  logic               in_transition_present;
  logic               in_frame_end;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_score;
  logic               out_no_path;
  logic               out_saturated;
  logic               cfg_we;
  logic [0:0]         cfg_index;
  logic [5:0]         cfg_data;

  viterbi_board board;
  int  burst_left;
  bit  press_req;
  bit  press_done;
  int  press_count;
  int  stall_mode;
  int  mode_left;
  int  loaded_dims [$];

  hmm_viterbi_gaussian_scorer_top DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Hard stop if the block hangs.
  initial begin
    #5ms;
    $display("testbench: done, errors");
    $finish;
  end

  // Receiver: stall on a pattern whose mode changes at random intervals, and hold off
  // for a long stretch once on request so the block backs up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
      stall_mode <= 0;
      mode_left <= 0;
      press_done <= 0;
      press_count <= 0;
    end else if (press_req && !press_done) begin
      out_stall <= 1;
      press_count <= press_count + 1;
      if (press_count == 2000) press_done <= 1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(8, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        default: out_stall <= ($urandom_range(0, 99) < 75);
      endcase
    end
  end

  // Check every result word at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_word(out_score, out_no_path, out_saturated);
  end

  // Offer one word and hold it until taken; then maybe end the burst and idle a while.
  task automatic send_word(op_t op, int st, int dim, int tg, logic [31:0] val,
                           bit pres, bit fend);
    in_op <= op;
    in_state_index <= 5'(st);
    in_dim_index <= 5'(dim);
    in_target_index <= 5'(tg);
    in_value <= val;
    in_transition_present <= pres;
    in_frame_end <= fend;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    board.note_word(op, st, dim, tg, val, pres, fend);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  // Let the block go idle: no word owed and the longest frame close has run out.
  task automatic drain();
    in_valid <= 0;
    while (board.score_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= 6'(data);
    @(posedge clk);
    board.write_cfg(idx, data);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // Q8.8 word: mostly moderate, sometimes the extremes.
  function automatic logic [31:0] feat_val();
    case ($urandom_range(0, 9))
      0: return {16'($urandom_range(0, 65535)), 16'h7FFF};
      1: return {16'($urandom_range(0, 65535)), 16'h8000};
      2: return $urandom;
      default: return $urandom_range(0, 2047) - 1024;
    endcase
  endfunction

  function automatic logic [31:0] hprec_val();
    return ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 255);
  endfunction

  function automatic logic [31:0] log_val();
    return ($urandom_range(0, 9) == 0) ? $urandom : -$urandom_range(0, 32'h0008_0000);
  endfunction

  // Load every state for a few dims, all constants, and a left-to-right transition set.
  task automatic load_model();
    int s, d, dim;
    s = board.n_states();
    d = board.n_dims();
    loaded_dims.delete();
    repeat ((d < 3) ? d : 3) begin
      dim = $urandom_range(0, d - 1);
      loaded_dims.push_back(dim);
      for (int j = 1; j <= s; j++) begin
        send_word(OP_MEAN, j, dim, $urandom_range(0, 31), feat_val(), 1'($urandom),
                  1'($urandom));
        send_word(OP_HPREC, j, dim, $urandom_range(0, 31), hprec_val(), 1'($urandom),
                  1'($urandom));
      end
    end
    for (int j = 1; j <= s; j++)
      send_word(OP_CONST, j, $urandom_range(0, 31), 0, log_val(), 1'($urandom),
                1'($urandom));
    for (int i = 0; i <= s; i++) begin
      send_word(OP_TRANS, i, 0, i + 1, log_val(), $urandom_range(0, 9) != 0, 1'($urandom));
      if (i > 0)
        send_word(OP_TRANS, i, 0, i, log_val(), $urandom_range(0, 3) != 0, 1'($urandom));
      if (i > 0 && (i == s || $urandom_range(0, 2) == 0))
        send_word(OP_TRANS, i, 0, s + 1, log_val(), 1, 1'($urandom));
    end
  endtask

  function automatic int pick_dim();
    int dim;
    dim = $urandom_range(0, 31);
    if (board.dim_ready(dim)) return dim;
    return loaded_dims[$urandom_range(0, loaded_dims.size() - 1)];
  endfunction

  // One utterance: start, a few frames, finish; sometimes a trailing partial frame.
  task automatic run_utterance(ref int sent);
    send_word(OP_START, $urandom_range(0, 31), $urandom_range(0, 31), 0, $urandom, 0, 0);
    sent++;
    repeat ($urandom_range(0, 4)) begin
      repeat ($urandom_range(0, 4)) begin
        send_word(OP_FEAT, $urandom_range(0, 31), pick_dim(), $urandom_range(0, 31),
                  feat_val(), 1'($urandom), 0);
        sent++;
      end
      send_word(OP_FEAT, $urandom_range(0, 31), pick_dim(), $urandom_range(0, 31),
                feat_val(), 1'($urandom), 1);
      sent++;
    end
    if ($urandom_range(0, 4) == 0) begin
      send_word(OP_FEAT, 0, pick_dim(), 0, feat_val(), 0, 0);
      sent++;
    end
    send_word(OP_FINISH, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
              $urandom, 1'($urandom), 1'($urandom));
    sent++;
  endtask

  // Noise: any op with random fields, keeping feature words off unloaded table entries.
  task automatic send_noise();
    logic [2:0] op;
    int dim;
    bit fend;
    op = 3'($urandom_range(0, 7));
    dim = $urandom_range(0, 31);
    fend = 1'($urandom);
    if (op == OP_FEAT) begin
      dim = pick_dim();
      if (!board.consts_ready()) fend = 0;
    end
    send_word(op_t'(op), $urandom_range(0, 31), dim, $urandom_range(0, 31), $urandom,
              1'($urandom), fend);
  endtask

  initial begin
    int phase_states [8] = '{2, 1, 0, 31, 16, 4, 3, 16};
    int phase_dims [8]   = '{2, 1, 0, 63, 32, 8, 5, 4};
    int sent;
    board = new();
    burst_left = 4;
    press_req = 0;
    rst_n <= 0;
    in_valid <= 0;
    in_op <= OP_MEAN;
    in_state_index <= 0;
    in_dim_index <= 0;
    in_target_index <= 0;
    in_value <= 0;
    in_transition_present <= 0;
    in_frame_end <= 0;
    cfg_we <= 0;
    cfg_index <= CFG_STATES;
    cfg_data <= 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: two states, two dims, extreme values and the special cases.
    write_reg(CFG_STATES, 2);
    write_reg(CFG_DIMS, 2);
    send_word(OP_FINISH, 0, 0, 0, 0, 0, 0);                 // nothing loaded: no path
    send_word(OP_MEAN, 1, 0, 0, 32'h0000_7FFF, 0, 0);
    send_word(OP_MEAN, 2, 0, 0, 32'hFFFF_8000, 0, 0);
    send_word(OP_HPREC, 1, 0, 0, 32'h0000_FFFF, 0, 0);
    send_word(OP_HPREC, 2, 0, 0, 32'h0000_0100, 0, 0);
    send_word(OP_MEAN, 3, 0, 0, 32'h1234, 0, 0);            // state beyond the model: drop
    send_word(OP_MEAN, 1, 2, 0, 32'h1234, 0, 0);            // dim beyond the model: drop
    send_word(OP_CONST, 1, 0, 0, 32'h7FFF_FFFF, 0, 0);
    send_word(OP_CONST, 2, 0, 0, 32'h8000_0000, 0, 0);
    send_word(OP_TRANS, 0, 0, 1, 0, 1, 0);
    send_word(OP_TRANS, 1, 0, 2, 32'hFFFF_0000, 1, 0);
    send_word(OP_TRANS, 1, 0, 0, 0, 1, 0);                  // into entry: never used
    send_word(OP_TRANS, 0, 0, 3, 0, 1, 0);                  // into exit while framing
    send_word(OP_TRANS, 2, 0, 3, 32'hFFFF_8000, 1, 0);
    send_word(OP_TRANS, 31, 0, 31, 0, 1, 0);                // off the table: drop
    send_word(OP_START, 0, 0, 0, 0, 0, 0);
    send_word(OP_FEAT, 0, 0, 0, 32'h0000_8000, 0, 1);
    send_word(OP_FEAT, 0, 31, 0, 32'h0000_7FFF, 0, 1);      // out-of-range dim still closes
    send_word(OP_FEAT, 0, 0, 0, 32'h0000_0000, 0, 0);       // partial frame left open
    send_word(op_t'(3'd7), 0, 0, 0, 0, 0, 0);               // unused op: no word
    send_word(OP_FINISH, 0, 0, 0, 0, 0, 0);
    drain();

    // Random phases across register settings, extremes included.
    foreach (phase_states[p]) begin
      write_reg(CFG_STATES, phase_states[p]);
      write_reg(CFG_DIMS, phase_dims[p]);
      load_model();
      sent = 0;
      while (sent < 20) begin
        if (p == 4 && sent > 2) press_req = 1;
        if ($urandom_range(0, 9) == 0) begin
          send_noise();
          sent++;
        end else begin
          run_utterance(sent);
        end
      end
      drain();
    end

    if (board.errors == 0 && board.score_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

>>> hmm_viterbi_gaussian_scorer_top.f
design/hvgs_pkg.sv
design/hvgs_cell.sv
design/hmm_viterbi_gaussian_scorer_top.sv
sim/testbench.sv
